// ===== src/c3z_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and register codes for the 3x3 zero-padded convolution.
// Used by the channel interfaces and by every module of the block.
package c3z_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int PIXEL_BITS = 16;
	localparam int COEF_FRAC_BITS = 12;
	localparam int SIDE = 3;
	localparam int TAPS = SIDE * SIDE;

	localparam int DIM_W = 11;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int COEF_W = 16;
	localparam int CREG_W = SIDE * COEF_W;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = CREG_W;

	localparam int PROD_W = PIXEL_BITS + COEF_W;
	localparam int RSUM_W = PROD_W + 2;
	localparam int ACC_W = PROD_W + 4;

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_MID = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_BOT = 3'd4;

	localparam logic [DIM_W-1:0] RST_WIDTH = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] RST_HEIGHT = DIM_W'(MAX_HEIGHT);
	localparam logic [CREG_W-1:0] RST_COEF_MID =
		CREG_W'(1 << (COEF_W + COEF_FRAC_BITS));

	localparam logic signed [ACC_W-1:0] ROUND_ADD =
		(COEF_FRAC_BITS > 0) ? ACC_W'(1 << ((COEF_FRAC_BITS > 0) ? COEF_FRAC_BITS - 1 : 0))
		: ACC_W'(0);
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 << (PIXEL_BITS - 1)) - 1);
	localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

	typedef logic [PIXEL_BITS-1:0] pixel_t;
	typedef logic [TAPS-1:0][PIXEL_BITS-1:0] window_t;
	typedef logic [SIDE-1:0][CREG_W-1:0] coefs_t;

	typedef struct packed {
		logic prod;
		logic last;
		logic top_off;
		logic bottom_off;
		logic left_off;
		logic right_off;
	} tap_info_t;

	typedef struct packed {
		logic take;
		logic [COL_W-1:0] col;
		pixel_t newpix;
		tap_info_t info;
	} issue_t;

	typedef struct packed {
		pixel_t value;
		logic sat;
		logic last;
	} result_t;

endpackage

// ===== src/c3z_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces of the convolution block: pixel input, result output and
// configuration write. Widths come from c3z_pkg.
interface c3z_in_if;
	logic valid;
	logic ready;
	logic func;
	logic [c3z_pkg::PIXEL_BITS-1:0] pixel;

	modport source(output valid, output func, output pixel, input ready);
	modport sink(input valid, input func, input pixel, output ready);
endinterface

interface c3z_out_if;
	logic valid;
	logic ready;
	logic [c3z_pkg::PIXEL_BITS-1:0] value;
	logic saturated;
	logic frame_last;

	modport source(output valid, output value, output saturated, output frame_last,
		input ready);
	modport sink(input valid, input value, input saturated, input frame_last,
		output ready);
endinterface

interface c3z_cfg_if;
	logic valid;
	logic ready;
	logic [c3z_pkg::CFG_IDX_W-1:0] index;
	logic [c3z_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ===== src/c3z_ctrl.sv =====
`timescale 1ns / 1ps
// Configuration registers and stream position counters of the convolution.
// Decides per transaction whether it produces a result and issues the line access.
module c3z_ctrl (
	input logic clk,
	input logic arst_n,
	c3z_cfg_if.sink cfg,
	input logic accept,
	input logic func,
	input logic [c3z_pkg::PIXEL_BITS-1:0] pixel,
	output c3z_pkg::issue_t issue,
	output c3z_pkg::coefs_t coefs
);

	localparam int DW = c3z_pkg::DIM_W;
	localparam int CLW = c3z_pkg::COL_W;

	logic [DW-1:0] width_q;
	logic [DW-1:0] height_q;
	logic [c3z_pkg::CREG_W-1:0] coef_top_q;
	logic [c3z_pkg::CREG_W-1:0] coef_mid_q;
	logic [c3z_pkg::CREG_W-1:0] coef_bot_q;
	logic [CLW-1:0] in_col_q;
	logic [DW-1:0] in_row_q;
	logic [CLW-1:0] out_col_q;
	logic [DW-1:0] out_row_q;

	logic cfg_we;
	logic inputs_done;
	logic take;
	logic started;
	logic prod;
	logic last;
	logic in_wrap;
	logic out_wrap;

	function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v,
		input logic [DW-1:0] hi);
		logic [DW-1:0] r;
		r = v;
		if (v == '0) begin
			r = DW'(1);
		end else if (v > hi) begin
			r = hi;
		end
		return r;
	endfunction

	assign cfg.ready = 1'b1;
	assign cfg_we = cfg.valid && cfg.ready;

	assign inputs_done = in_row_q >= height_q;
	assign take = accept && !(func && !inputs_done);
	assign started = (in_row_q > DW'(1)) || ((in_row_q == DW'(1)) && (in_col_q != '0));
	assign prod = take && started && (out_row_q < height_q);
	assign last = (out_row_q == DW'(height_q - DW'(1)))
		&& (DW'(out_col_q) == DW'(width_q - DW'(1)));
	assign in_wrap = DW'(DW'(in_col_q) + DW'(1)) >= width_q;
	assign out_wrap = DW'(DW'(out_col_q) + DW'(1)) >= width_q;

	always_comb begin
		issue.take = take;
		issue.col = in_col_q;
		issue.newpix = inputs_done ? '0 : pixel;
		issue.info.prod = prod;
		issue.info.last = last;
		issue.info.top_off = out_row_q == '0;
		issue.info.bottom_off = DW'(out_row_q + DW'(1)) >= height_q;
		issue.info.left_off = out_col_q == '0;
		issue.info.right_off = out_wrap;
	end

	assign coefs = {coef_bot_q, coef_mid_q, coef_top_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= c3z_pkg::RST_WIDTH;
			height_q <= c3z_pkg::RST_HEIGHT;
			coef_top_q <= '0;
			coef_mid_q <= c3z_pkg::RST_COEF_MID;
			coef_bot_q <= '0;
		end else if (cfg_we) begin
			case (cfg.index)
				c3z_pkg::REG_WIDTH: begin
					width_q <= clamp_dim(cfg.data[DW-1:0], DW'(c3z_pkg::MAX_WIDTH));
				end
				c3z_pkg::REG_HEIGHT: begin
					height_q <= clamp_dim(cfg.data[DW-1:0], DW'(c3z_pkg::MAX_HEIGHT));
				end
				c3z_pkg::REG_COEF_TOP: begin
					coef_top_q <= cfg.data[c3z_pkg::CREG_W-1:0];
				end
				c3z_pkg::REG_COEF_MID: begin
					coef_mid_q <= cfg.data[c3z_pkg::CREG_W-1:0];
				end
				c3z_pkg::REG_COEF_BOT: begin
					coef_bot_q <= cfg.data[c3z_pkg::CREG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q <= '0;
			in_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_we && ((cfg.index == c3z_pkg::REG_WIDTH)
			|| (cfg.index == c3z_pkg::REG_HEIGHT))) begin
			in_col_q <= '0;
			in_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (take) begin
			if (prod && last) begin
				in_col_q <= '0;
				in_row_q <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (prod) begin
					if (out_wrap) begin
						out_col_q <= '0;
						out_row_q <= DW'(out_row_q + DW'(1));
					end else begin
						out_col_q <= CLW'(out_col_q + 1'b1);
					end
				end
				if (in_wrap) begin
					in_col_q <= '0;
					in_row_q <= DW'(in_row_q + DW'(1));
				end else begin
					in_col_q <= CLW'(in_col_q + 1'b1);
				end
			end
		end
	end

endmodule

// ===== src/c3z_line_buf.sv =====
`timescale 1ns / 1ps
// Two-line pixel memory with read-modify-write per transaction and the 3x3 window.
// Depends on c3z_pkg for widths and the issue and tap information types.
module c3z_line_buf (
	input logic clk,
	input logic arst_n,
	input c3z_pkg::issue_t issue,
	output c3z_pkg::window_t window,
	output c3z_pkg::tap_info_t info
);

	localparam int PB = c3z_pkg::PIXEL_BITS;
	localparam int SIDE = c3z_pkg::SIDE;

	logic [2*PB-1:0] mem [c3z_pkg::MAX_WIDTH];
	logic [2*PB-1:0] rd_q;

	logic take_s1;
	logic [c3z_pkg::COL_W-1:0] col_s1;
	c3z_pkg::pixel_t newpix_s1;
	c3z_pkg::tap_info_t info_s1;
	logic hz_s1;
	logic [2*PB-1:0] fwd_s1;

	logic [2*PB-1:0] rd_data;
	logic [2*PB-1:0] wr_data;
	c3z_pkg::window_t win_q;
	c3z_pkg::tap_info_t info_s2;

	assign rd_data = hz_s1 ? fwd_s1 : rd_q;
	assign wr_data = {rd_data[PB-1:0], newpix_s1};

	always_ff @(posedge clk) begin
		if (issue.take) begin
			rd_q <= mem[issue.col];
		end
		if (take_s1) begin
			mem[col_s1] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (issue.take) begin
			col_s1 <= issue.col;
			newpix_s1 <= issue.newpix;
			info_s1 <= issue.info;
			hz_s1 <= take_s1 && (col_s1 == issue.col);
			fwd_s1 <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			take_s1 <= 1'b0;
		end else begin
			take_s1 <= issue.take;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			info_s2 <= '0;
		end else begin
			info_s2 <= take_s1 ? info_s1 : '0;
			if (take_s1) begin
				for (int r = 0; r < SIDE; r++) begin
					win_q[r*SIDE] <= win_q[r*SIDE+1];
					win_q[r*SIDE+1] <= win_q[r*SIDE+2];
				end
				win_q[2] <= rd_data[2*PB-1:PB];
				win_q[5] <= rd_data[PB-1:0];
				win_q[8] <= newpix_s1;
			end
		end
	end

	assign window = win_q;
	assign info = info_s2;

endmodule

// ===== src/c3z_mac.sv =====
`timescale 1ns / 1ps
// Nine masked products, row sums, rounding shift and saturation of the window.
// Depends on c3z_pkg for widths, rounding and saturation constants.
module c3z_mac (
	input logic clk,
	input logic arst_n,
	input c3z_pkg::window_t window,
	input c3z_pkg::tap_info_t info,
	input c3z_pkg::coefs_t coefs,
	output logic push,
	output c3z_pkg::result_t push_data
);

	localparam int SIDE = c3z_pkg::SIDE;
	localparam int PW = c3z_pkg::PROD_W;
	localparam int RW = c3z_pkg::RSUM_W;
	localparam int AW = c3z_pkg::ACC_W;
	localparam int CW = c3z_pkg::COEF_W;

	logic signed [PW-1:0] prod_s3 [c3z_pkg::TAPS];
	logic signed [RW-1:0] rsum_s4 [SIDE];
	logic v_s3, v_s4, v_s5;
	logic last_s3, last_s4;
	c3z_pkg::result_t res_s5;

	logic signed [AW-1:0] acc;
	logic signed [AW-1:0] rnd;
	logic signed [AW-1:0] shr;

	for (genvar dy = 0; dy < SIDE; dy++) begin : g_row
		for (genvar dx = 0; dx < SIDE; dx++) begin : g_col
			logic off;
			logic signed [CW-1:0] coef;
			logic signed [c3z_pkg::PIXEL_BITS-1:0] pix;

			assign off = (dy == 0 && info.top_off) || (dy == SIDE - 1 && info.bottom_off)
				|| (dx == 0 && info.left_off) || (dx == SIDE - 1 && info.right_off);
			assign coef = coefs[dy][dx*CW +: CW];
			assign pix = window[dy*SIDE+dx];

			always_ff @(posedge clk) begin
				if (info.prod) begin
					prod_s3[dy*SIDE+dx] <= off ? '0 : PW'(pix * coef);
				end
			end
		end

		always_ff @(posedge clk) begin
			if (v_s3) begin
				rsum_s4[dy] <= RW'(prod_s3[dy*SIDE]) + RW'(prod_s3[dy*SIDE+1])
					+ RW'(prod_s3[dy*SIDE+2]);
			end
		end
	end

	always_comb begin
		acc = AW'(rsum_s4[0]) + AW'(rsum_s4[1]) + AW'(rsum_s4[2]);
		rnd = acc + c3z_pkg::ROUND_ADD;
		shr = rnd >>> c3z_pkg::COEF_FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (info.prod) begin
			last_s3 <= info.last;
		end
		if (v_s3) begin
			last_s4 <= last_s3;
		end
		if (v_s4) begin
			res_s5.last <= last_s4;
			if (shr > c3z_pkg::SAT_HI) begin
				res_s5.value <= c3z_pkg::SAT_HI[c3z_pkg::PIXEL_BITS-1:0];
				res_s5.sat <= 1'b1;
			end else if (shr < c3z_pkg::SAT_LO) begin
				res_s5.value <= c3z_pkg::SAT_LO[c3z_pkg::PIXEL_BITS-1:0];
				res_s5.sat <= 1'b1;
			end else begin
				res_s5.value <= shr[c3z_pkg::PIXEL_BITS-1:0];
				res_s5.sat <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s3 <= info.prod;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	assign push = v_s5;
	assign push_data = res_s5;

endmodule

// ===== src/c3z_out_fifo.sv =====
`timescale 1ns / 1ps
// Result queue with credit count covering results still inside the pipeline.
// Depends on c3z_pkg for the result type and the queue depth.
module c3z_out_fifo (
	input logic clk,
	input logic arst_n,
	input logic reserve,
	input logic push,
	input c3z_pkg::result_t push_data,
	output logic room,
	c3z_out_if.source out
);

	localparam int AW = c3z_pkg::FIFO_AW;

	c3z_pkg::result_t mem [c3z_pkg::FIFO_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0] cnt_q;
	logic [AW:0] occ_q;
	logic pop;

	assign pop = out.valid && out.ready;
	assign room = occ_q != (AW+1)'(c3z_pkg::FIFO_DEPTH);

	assign out.valid = cnt_q != '0;
	assign out.value = mem[rd_ptr_q].value;
	assign out.saturated = mem[rd_ptr_q].sat;
	assign out.frame_last = mem[rd_ptr_q].last;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
			occ_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= AW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= AW'(rd_ptr_q + 1'b1);
			end
			cnt_q <= (AW+1)'(cnt_q + (AW+1)'(push) - (AW+1)'(pop));
			occ_q <= (AW+1)'(occ_q + (AW+1)'(reserve) - (AW+1)'(pop));
		end
	end

endmodule

// ===== src/conv3x3_zero_padded.sv =====
`timescale 1ns / 1ps
// 3x3 zero-padded convolution over a raster pixel stream, Q8.8 pixels, Q4.12 taps.
// Throughput: one transaction per clock while the result queue has room, set by
// the single read-modify-write of the line memory per transaction, with forwarding
// between neighbors. Results pass read, window, product, row-sum and result registers.
// Reset: arst_n clears counters, window, pipeline and queue and restores the default
// registers; the line memory is not cleared, as out-of-image taps are masked.
module conv3x3_zero_padded (
	input logic clk,
	input logic arst_n,
	c3z_in_if.sink pix_in,
	c3z_out_if.source pix_out,
	c3z_cfg_if.sink cfg
);

	logic room;
	logic accept;
	c3z_pkg::issue_t issue;
	c3z_pkg::coefs_t coefs;
	c3z_pkg::window_t window;
	c3z_pkg::tap_info_t info;
	logic push;
	c3z_pkg::result_t push_data;

	assign pix_in.ready = room;
	assign accept = pix_in.valid && pix_in.ready;

	c3z_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.accept(accept),
		.func(pix_in.func),
		.pixel(pix_in.pixel),
		.issue(issue),
		.coefs(coefs)
	);

	c3z_line_buf u_line_buf (
		.clk(clk),
		.arst_n(arst_n),
		.issue(issue),
		.window(window),
		.info(info)
	);

	c3z_mac u_mac (
		.clk(clk),
		.arst_n(arst_n),
		.window(window),
		.info(info),
		.coefs(coefs),
		.push(push),
		.push_data(push_data)
	);

	c3z_out_fifo u_out_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.reserve(issue.info.prod),
		.push(push),
		.push_data(push_data),
		.room(room),
		.out(pix_out)
	);

endmodule
